// ----- sv/pgoc_pkg.sv -----
// Shared widths, codes and types of the pixel gain/offset corrector.
package pgoc_pkg;

   // Default depth exponent of the nonlinearity table
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int TABLE_W  = 18;
   localparam int OFFSET_W = 24;
   localparam int GAIN_W   = 20;
   localparam int BG_W     = 24;

   // Request data packing, lowest field first
   localparam int TDATA_SAMPLE_LSB = 0;
   localparam int TDATA_TABLE_LSB  = TDATA_SAMPLE_LSB + SAMPLE_W;
   localparam int TDATA_OFFSET_LSB = TDATA_TABLE_LSB + TABLE_W;
   localparam int TDATA_GAIN_LSB   = TDATA_OFFSET_LSB + OFFSET_W;
   localparam int REQ_FIELDS_W     = TDATA_GAIN_LSB + GAIN_W;
   localparam int REQ_TDATA_W      = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W      = SAMPLE_W;

   // Datapath widths: table-corrected sample, Q.8 difference, Q.24 product
   localparam int DIFF_W     = TABLE_W + 1;
   localparam int V_W        = SAMPLE_W + 10;
   localparam int PROD_W     = V_W + GAIN_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int FRAC_SHIFT = 24;
   localparam int BG_SHIFT   = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_INL_ENABLE = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND = CSR_INDEX_W'(1);

   // Request kinds carried on tuser
   localparam logic OP_TABLE_WRITE = 1'b0;
   localparam logic OP_CORRECT     = 1'b1;

   typedef struct packed {
      logic            inl_enable;
      logic [BG_W-1:0] background;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0]        sample;
      logic signed [OFFSET_W-1:0] offset;
      logic signed [GAIN_W-1:0]   gain;
      logic                       last;
   } item_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] corrected_sample;
      logic                last;
   } rsp_type;

endpackage

// ----- sv/pgoc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pgoc_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pgoc_csr.sv -----
// Configuration registers: table enable and background level.
module pgoc_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pgoc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pgoc_pkg::BG_W-1:0]         csr_data,
   output pgoc_pkg::cfg_type                 cfg
);

   import pgoc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_INL_ENABLE: cfg_in.inl_enable = csr_data[0];
            CSR_BACKGROUND: cfg_in.background = csr_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

// ----- sv/pgoc_calc.sv -----
// Correction: table subtract/clamp, offset, gain multiply, background, round and saturate.
module pgoc_calc #(
   parameter int SAMPLE_BITS = pgoc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pgoc_pkg::cfg_type            cfg,
   input  logic                         in_load,
   output logic                         in_ready,
   input  pgoc_pkg::item_type           in_item,
   input  logic [pgoc_pkg::TABLE_W-1:0] tbl_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output pgoc_pkg::rsp_type            out_rsp
);

   import pgoc_pkg::*;

   localparam logic signed [DIFF_W-1:0] DIFF_MAX = DIFF_W'((1 << SAMPLE_BITS) - 1);
   localparam logic [ACC_W-FRAC_SHIFT-2:0] RES_MAX =
      (ACC_W-FRAC_SHIFT-1)'((1 << SAMPLE_BITS) - 1);
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);

   // Stage 1: request registered, table word arrives from the RAM
   logic                       s1_valid_ff, s1_valid_in;
   logic [SAMPLE_BITS-1:0]     s1_sample_ff;
   logic signed [OFFSET_W-1:0] s1_offset_ff;
   logic signed [GAIN_W-1:0]   s1_gain_ff;
   logic                       s1_last_ff;
   // Stage 2: Q.8 difference
   logic                       s2_valid_ff, s2_valid_in;
   logic signed [V_W-1:0]      s2_v_ff, s2_v_in;
   logic signed [GAIN_W-1:0]   s2_gain_ff;
   logic                       s2_last_ff;
   // Stage 3: Q.24 product
   logic                       s3_valid_ff, s3_valid_in;
   logic signed [PROD_W-1:0]   s3_prod_ff, s3_prod_in;
   logic                       s3_last_ff;
   // Output register
   logic                       out_valid_ff, out_valid_in;
   rsp_type                    out_rsp_ff, out_rsp_in;

   logic out_adv, s3_adv, s2_adv, s1_adv;

   logic signed [DIFF_W-1:0]  diff;
   logic [SAMPLE_BITS-1:0]    a_sel;
   logic signed [ACC_W-1:0]   acc;
   logic [ACC_W-FRAC_SHIFT-2:0] res_int;

   // Each stage moves when the one after it is empty or moving
   assign out_adv  = !out_valid_ff || out_ready;
   assign s3_adv   = !s3_valid_ff || out_adv;
   assign s2_adv   = !s2_valid_ff || s3_adv;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   // Table subtract and clamp to the sample range
   always_comb begin
      diff = $signed(DIFF_W'(s1_sample_ff)) - DIFF_W'($signed(tbl_data));
      if (!cfg.inl_enable) begin
         a_sel = s1_sample_ff;
      end else if (diff < 0) begin
         a_sel = '0;
      end else if (diff > DIFF_MAX) begin
         a_sel = DIFF_MAX[SAMPLE_BITS-1:0];
      end else begin
         a_sel = diff[SAMPLE_BITS-1:0];
      end
      s2_v_in = $signed(V_W'({a_sel, 8'b0})) - V_W'(s1_offset_ff);
   end

   assign s3_prod_in = s2_v_ff * s2_gain_ff;

   // Add background, round half up, saturate
   always_comb begin
      acc = ACC_W'(s3_prod_ff)
          + $signed(ACC_W'({cfg.background, BG_SHIFT'(0)}))
          + ROUND_HALF;
      res_int = acc[ACC_W-2:FRAC_SHIFT];
      out_rsp_in.last = s3_last_ff;
      if (acc[ACC_W-1]) begin
         out_rsp_in.corrected_sample = '0;
      end else if (res_int > RES_MAX) begin
         out_rsp_in.corrected_sample = SAMPLE_W'(RES_MAX);
      end else begin
         out_rsp_in.corrected_sample = SAMPLE_W'(res_int);
      end
   end

   assign s1_valid_in  = s1_adv ? in_load : s1_valid_ff;
   assign s2_valid_in  = s2_adv ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = s3_adv ? s2_valid_ff : s3_valid_ff;
   assign out_valid_in = out_adv ? s3_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && in_load) begin
         s1_sample_ff <= in_item.sample[SAMPLE_BITS-1:0];
         s1_offset_ff <= in_item.offset;
         s1_gain_ff   <= in_item.gain;
         s1_last_ff   <= in_item.last;
      end
      if (s2_adv && s1_valid_ff) begin
         s2_v_ff    <= s2_v_in;
         s2_gain_ff <= s1_gain_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (s3_adv && s2_valid_ff) begin
         s3_prod_ff <= s3_prod_in;
         s3_last_ff <= s2_last_ff;
      end
      if (out_adv && s3_valid_ff) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

endmodule

// ----- sv/pixel_gain_offset_corrector_unit.sv -----
// Top level of the per-pixel gain/offset corrector with nonlinearity table.
// Registered steps from request accept to rsp_tvalid: table read, difference, multiply, round.
// Throughput: one request per cycle while the response side is not stalling, set by the single
// table RAM port pair and the one multiplier. Table writes give no response.
// Reset clears the pipeline valids and the configuration registers; table contents stay
// undefined until written, with no clearing pass.
module pixel_gain_offset_corrector_unit #(
   parameter int SAMPLE_BITS = pgoc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: sample[15:0], table_word[33:16], pixel_offset[57:34], pixel_gain[77:58], zeros
   input  logic [pgoc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: op (0 table write, 1 correct sample)
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   // Response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: corrected_sample[15:0]
   output logic [pgoc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tlast,
   // Configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pgoc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pgoc_pkg::BG_W-1:0]         csr_data
);

   import pgoc_pkg::*;

   cfg_type                 cfg;
   item_type                item;
   rsp_type                 rsp;
   logic                    req_accept;
   logic                    ram_we;
   logic                    ram_re;
   logic [SAMPLE_BITS-1:0]  ram_addr;
   logic [TABLE_W-1:0]      ram_rd_data;

   pgoc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Unpack the request
   assign item.sample = req_tdata[TDATA_SAMPLE_LSB +: SAMPLE_W];
   assign item.offset = req_tdata[TDATA_OFFSET_LSB +: OFFSET_W];
   assign item.gain   = req_tdata[TDATA_GAIN_LSB +: GAIN_W];
   assign item.last   = req_tlast;

   // Every accepted request touches the table exactly once: a write for a table load,
   // a read for a sample. Reads follow writes in accept order, so a sample right after
   // a load of the same address sees the new word without forwarding.
   assign req_accept = req_tvalid && req_tready;
   assign ram_addr   = item.sample[SAMPLE_BITS-1:0];
   assign ram_we     = req_accept && (req_tuser == OP_TABLE_WRITE);
   assign ram_re     = req_accept && (req_tuser == OP_CORRECT);

   pgoc_ram #(
      .WIDTH (TABLE_W),
      .DEPTH (1 << SAMPLE_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (req_tdata[TDATA_TABLE_LSB +: TABLE_W]),
      .rd_en   (ram_re),
      .rd_addr (ram_addr),
      .rd_data (ram_rd_data)
   );

   // Read data holds while stage 1 stalls, since no new read issues until it moves on
   pgoc_calc #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_calc (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_load   (ram_re),
      .in_ready  (req_tready),
      .in_item   (item),
      .tbl_data  (ram_rd_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = rsp.corrected_sample;
   assign rsp_tlast = rsp.last;

   // Table port is never asked to read and write in the same cycle
   a_ram_single_access : assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("table read and write in the same cycle");

   // A draining output never throttles the request side
   a_full_rate : assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request stalled while response side is ready");

   // Saturated result stays inside the configured sample range
   a_sat_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata) <= ((32'd1 << SAMPLE_BITS) - 32'd1)))
      else $error("response beyond sample range");

   // Pipeline comes out of reset empty
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

// ----- tb/sv/pixel_correction_checker.sv -----
// Checker for the pixel corrector: tracks register and table writes, predicts and compares.
`timescale 1ns / 100ps

module pixel_correction_checker #(
   parameter int SAMPLE_BITS = pgoc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   // tdata: sample, table_word, pixel_offset, pixel_gain, zeros
   input  logic [pgoc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: op
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: corrected_sample
   input  logic [pgoc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             rsp_tlast,
   input  logic                             csr_valid,
   input  logic                             csr_ready,
   input  logic [pgoc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pgoc_pkg::BG_W-1:0]        csr_data,
   output int unsigned                      pending_count,
   output int unsigned                      mismatch_count
);

   import pgoc_pkg::*;

   localparam longint PIXEL_MAX = (longint'(1) << SAMPLE_BITS) - 1;
   localparam logic [SAMPLE_W-1:0] ADDR_MASK = SAMPLE_W'(PIXEL_MAX);

   cfg_type                   cfg;
   logic signed [TABLE_W-1:0] inl_table [0:(1 << SAMPLE_W)-1];
   rsp_type                   expected_pixels [$];
   int unsigned               errors = 0;

   initial begin
      pending_count  = 0;
      mismatch_count = 0;
   end

   // Table lookup and clamp when enabled, then (A - offset) * gain + background, round half up, saturate
   function automatic logic [SAMPLE_W-1:0] corrected_value(
      input logic [SAMPLE_W-1:0]        raw,
      input logic signed [OFFSET_W-1:0] offset,
      input logic signed [GAIN_W-1:0]   gain
   );
      logic [SAMPLE_W-1:0] addr;
      longint              level;
      longint              diff;
      longint              acc;
      addr  = raw & ADDR_MASK;
      level = longint'(addr);
      if (cfg.inl_enable) begin
         level = level - longint'(inl_table[addr]);
         if (level < 0)
            level = 0;
         else if (level > PIXEL_MAX)
            level = PIXEL_MAX;
      end
      diff = level * 256 - longint'(offset);
      acc  = diff * longint'(gain) + longint'(cfg.background) * (longint'(1) << BG_SHIFT)
             + (longint'(1) << (FRAC_SHIFT - 1));
      if (acc < 0)
         return '0;
      acc = acc >>> FRAC_SHIFT;
      if (acc > PIXEL_MAX)
         acc = PIXEL_MAX;
      return SAMPLE_W'(acc);
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      logic [REQ_TDATA_W-1:0] data;
      if (reset) begin
         cfg = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected result: corrected_sample %0d, frame_end_out %0b",
                      rsp_tdata, rsp_tlast);
               errors++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata !== want.corrected_sample) begin
                  $error("corrected_sample: expected %0d, actual %0d",
                         want.corrected_sample, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("frame_end_out: expected %0b, actual %0b", want.last, rsp_tlast);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            data = req_tdata;
            if (req_tuser == OP_TABLE_WRITE) begin
               inl_table[data[TDATA_SAMPLE_LSB +: SAMPLE_W] & ADDR_MASK] =
                  data[TDATA_TABLE_LSB +: TABLE_W];
            end else begin
               want.corrected_sample = corrected_value(data[TDATA_SAMPLE_LSB +: SAMPLE_W],
                                                       data[TDATA_OFFSET_LSB +: OFFSET_W],
                                                       data[TDATA_GAIN_LSB +: GAIN_W]);
               want.last = req_tlast;
               expected_pixels.push_back(want);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INL_ENABLE: cfg.inl_enable = csr_data[0];
               CSR_BACKGROUND: cfg.background = csr_data;
               default: ;
            endcase
         end
      end
      pending_count  <= expected_pixels.size();
      mismatch_count <= errors;
   end

endmodule

// ----- tb/sv/pixel_gain_offset_corrector_unit_tb.sv -----
// Testbench top for the pixel gain/offset corrector: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module pixel_gain_offset_corrector_unit_tb;
   import pgoc_pkg::*;

   localparam int SAMPLE_BITS     = SAMPLE_BITS_DEFAULT;
   localparam int RESET_CYCLES    = 7;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 235;
   // Drain covers the 4-stage pipeline, so trailing table writes settle before a register write
   localparam int DRAIN_CYCLES    = 12;
   localparam int HOLD_OFF_CYCLES = 250;
   // Covers roughly 1900 requests with the longest random gaps and heavy stalls plus two hold-offs,
   // several times over
   localparam int CYCLE_LIMIT     = 400000;

   // Indexes past the last register; writes there must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_INDEX = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_INDEX   = '1;

   localparam logic signed [TABLE_W-1:0]  WORD_MAX   = {1'b0, {(TABLE_W-1){1'b1}}};
   localparam logic signed [TABLE_W-1:0]  WORD_MIN   = {1'b1, {(TABLE_W-1){1'b0}}};
   localparam logic signed [OFFSET_W-1:0] OFFSET_MAX = {1'b0, {(OFFSET_W-1){1'b1}}};
   localparam logic signed [OFFSET_W-1:0] OFFSET_MIN = {1'b1, {(OFFSET_W-1){1'b0}}};
   localparam logic signed [GAIN_W-1:0]   GAIN_MAX   = {1'b0, {(GAIN_W-1){1'b1}}};
   localparam logic signed [GAIN_W-1:0]   GAIN_MIN   = {1'b1, {(GAIN_W-1){1'b0}}};
   // 1.0 in Q4.16 and half a count in Q16.8
   localparam logic signed [GAIN_W-1:0]   GAIN_UNITY  = GAIN_W'(65536);
   localparam logic signed [OFFSET_W-1:0] HALF_COUNT  = OFFSET_W'(128);
   localparam logic [SAMPLE_W-1:0]        SAMPLE_TOP  = '1;

   typedef enum int {RX_FREE, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tready = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [BG_W-1:0]        csr_data   = '0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_ready;
   int unsigned            pending_count;
   int unsigned            mismatch_count;

   int unsigned            cycle_count = 0;
   int unsigned            burst_left  = 0;
   int unsigned            hold_asks   = 0;
   int unsigned            holds_done  = 0;
   // Stimulus-side view of the table: only addresses written so far may be read with
   // the table enabled, since unwritten entries are undefined
   logic [SAMPLE_W-1:0]    written_addrs [$];
   bit                     seen_addr [int];
   logic [SAMPLE_W-1:0]    last_written = '0;
   logic                   inl_on = 1'b0;

   pixel_gain_offset_corrector_unit #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   pixel_correction_checker #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .pending_count  (pending_count),
      .mismatch_count (mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop in case the block hangs or drops a result
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Offer one request and hold it until accepted. Between bursts, drop valid for a
   // random gap; keep valid high across back-to-back requests inside a burst.
   task automatic send_request(
      input logic                       op,
      input logic [SAMPLE_W-1:0]        sample,
      input logic signed [TABLE_W-1:0]  word,
      input logic signed [OFFSET_W-1:0] offset,
      input logic signed [GAIN_W-1:0]   gain,
      input logic                       last
   );
      logic [REQ_TDATA_W-1:0] data;
      int unsigned            gap;
      data = '0;
      data[TDATA_SAMPLE_LSB +: SAMPLE_W] = sample;
      data[TDATA_TABLE_LSB +: TABLE_W]   = word;
      data[TDATA_OFFSET_LSB +: OFFSET_W] = offset;
      data[TDATA_GAIN_LSB +: GAIN_W]     = gain;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         // Mostly short bursts, now and then a long unbroken stretch
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 48);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (op == OP_TABLE_WRITE) begin
         last_written = sample;
         if (!seen_addr.exists(int'(sample))) begin
            seen_addr[int'(sample)] = 1'b1;
            written_addrs.push_back(sample);
         end
      end
   endtask

   // Write one register; drop valid for a cycle afterwards so the next write starts clean
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [BG_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (index == CSR_INL_ENABLE)
         inl_on = data[0];
   endtask

   // Stop offering, wait for every expected result, then let trailing table writes drain
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One random request: mostly pixels with offsets and gains in a realistic range,
   // mixed with full-range values, extremes and table writes
   task automatic send_random_item();
      logic                       op;
      logic [SAMPLE_W-1:0]        sample;
      logic signed [TABLE_W-1:0]  word;
      logic signed [OFFSET_W-1:0] offset;
      logic signed [GAIN_W-1:0]   gain;
      op = ($urandom_range(0, 7) == 0) ? OP_TABLE_WRITE : OP_CORRECT;

      case ($urandom_range(0, 5))
         0:       word = WORD_MIN;
         1:       word = WORD_MAX;
         2, 3:    word = TABLE_W'($urandom);
         default: word = TABLE_W'(int'($urandom_range(0, 600)) - 300);
      endcase

      case ($urandom_range(0, 9))
         0:       offset = $urandom_range(0, 1) ? OFFSET_MAX : OFFSET_MIN;
         1, 2:    offset = OFFSET_W'($urandom);
         default: offset = OFFSET_W'(int'($urandom_range(0, 2 * 4096 * 256)) - 4096 * 256);
      endcase

      case ($urandom_range(0, 9))
         0:       gain = $urandom_range(0, 1) ? GAIN_MAX : GAIN_MIN;
         1:       gain = '0;
         2, 3:    gain = GAIN_W'($urandom);
         default: gain = GAIN_UNITY + GAIN_W'(int'($urandom_range(0, 65536)) - 32768);
      endcase

      if (op == OP_TABLE_WRITE) begin
         // Rewrite known entries half the time so reads see overwritten words
         if (written_addrs.size() != 0 && $urandom_range(0, 1) == 1)
            sample = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
         else
            sample = SAMPLE_W'($urandom);
      end else if (inl_on) begin
         // Read only written entries; favor the latest one to hit read-after-write
         if ($urandom_range(0, 3) == 0)
            sample = last_written;
         else
            sample = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
      end else begin
         case ($urandom_range(0, 9))
            0:       sample = '0;
            1:       sample = SAMPLE_TOP;
            default: sample = SAMPLE_W'($urandom);
         endcase
      end

      send_request(op, sample, word, offset, gain, $urandom_range(0, 15) == 0);
   endtask

   // Response side: stall on changing patterns; on request, hold off for a long stretch
   // so the pipeline fills and backs up into the request channel
   initial begin
      rx_pattern_type pattern;
      int unsigned    span;
      int unsigned    step_idx;
      forever begin
         if (hold_asks != holds_done) begin
            repeat (HOLD_OFF_CYCLES) begin
               @(posedge clock);
               rsp_tready <= 1'b0;
            end
            holds_done++;
         end else begin
            pattern = rx_pattern_type'($urandom_range(0, 3));
            span    = $urandom_range(8, 80);
            for (step_idx = 0; step_idx < span; step_idx++) begin
               @(posedge clock);
               case (pattern)
                  RX_FREE:   rsp_tready <= 1'b1;
                  RX_HALF:   rsp_tready <= $urandom_range(0, 1) == 1;
                  RX_SPARSE: rsp_tready <= $urandom_range(0, 3) == 0;
                  default:   rsp_tready <= (step_idx % 8) < 5;
               endcase
            end
         end
      end
   end

   initial begin
      int unsigned     phase;
      int unsigned     n;
      logic            inl;
      logic [BG_W-1:0] bg;
      logic [BG_W-1:0] enable_word;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // Registers at reset values, then writes to unused indexes with all ones;
      // a bad decode would switch the table on or raise the background
      write_reg(CSR_BACKGROUND, '0);
      write_reg(CSR_INL_ENABLE, '0);
      write_reg(CSR_SPARE_INDEX, '1);
      write_reg(CSR_TOP_INDEX, '1);

      // Plain gain and offset: extremes, saturation both ways, rounding at half a count
      send_request(OP_CORRECT, '0, '0, '0, GAIN_UNITY, 1'b0);
      send_request(OP_CORRECT, SAMPLE_TOP, '0, '0, GAIN_UNITY, 1'b0);
      send_request(OP_CORRECT, SAMPLE_TOP, '0, OFFSET_MIN, GAIN_MAX, 1'b0);
      send_request(OP_CORRECT, '0, '0, OFFSET_MAX, GAIN_MAX, 1'b0);
      send_request(OP_CORRECT, SAMPLE_W'(1), '0, HALF_COUNT, GAIN_UNITY, 1'b0);
      send_request(OP_CORRECT, SAMPLE_W'(1), '0, HALF_COUNT + OFFSET_W'(1), GAIN_UNITY, 1'b0);
      send_request(OP_CORRECT, SAMPLE_W'(1000), '0, '0, GAIN_MIN, 1'b0);
      // Negative difference times most negative gain: large positive, clips high
      send_request(OP_CORRECT, '0, '0, OFFSET_MAX, GAIN_MIN, 1'b0);
      send_request(OP_CORRECT, SAMPLE_W'(12345), '0, '0, '0, 1'b1);

      // Table words at both ends of the address and value ranges
      send_request(OP_TABLE_WRITE, '0, WORD_MAX, '0, '0, 1'b0);
      send_request(OP_TABLE_WRITE, SAMPLE_TOP, WORD_MIN, OFFSET_MAX, GAIN_MAX, 1'b1);
      send_request(OP_TABLE_WRITE, SAMPLE_W'(16'h5A5A), TABLE_W'(100), '0, '0, 1'b0);
      send_request(OP_TABLE_WRITE, SAMPLE_W'(16'hA5A5), TABLE_W'(-100), '0, '0, 1'b0);

      // Table on, background of 10 counts in Q16.8
      wait_idle();
      write_reg(CSR_INL_ENABLE, BG_W'(1));
      write_reg(CSR_BACKGROUND, BG_W'(10 * 256));

      // Clamp to zero and to full scale after the table step, then ordinary entries
      send_request(OP_CORRECT, '0, '0, '0, GAIN_UNITY, 1'b0);
      send_request(OP_CORRECT, SAMPLE_TOP, '0, '0, GAIN_UNITY, 1'b0);
      send_request(OP_CORRECT, SAMPLE_W'(16'h5A5A), '0, '0, GAIN_UNITY, 1'b0);
      send_request(OP_CORRECT, SAMPLE_W'(16'hA5A5), '0, '0, GAIN_UNITY, 1'b1);
      // Rewrite an entry and read it right behind the write
      send_request(OP_TABLE_WRITE, SAMPLE_W'(16'h5A5A), TABLE_W'(-5), '0, '0, 1'b0);
      send_request(OP_CORRECT, SAMPLE_W'(16'h5A5A), '0, '0, GAIN_UNITY, 1'b0);
      send_request(OP_TABLE_WRITE, '0, '0, '0, '0, 1'b0);
      send_request(OP_CORRECT, '0, '0, OFFSET_W'(-256), GAIN_UNITY, 1'b1);

      // Random phases: table off for the first half, on for the second, each with
      // zero, full-scale, random and small backgrounds
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         inl = phase[2];
         case (phase % 4)
            0:       bg = '0;
            1:       bg = '1;
            2:       bg = BG_W'($urandom);
            default: bg = BG_W'($urandom_range(0, 2000 * 256));
         endcase
         // Upper bits of the enable write are don't-care; drive them random
         enable_word    = BG_W'($urandom);
         enable_word[0] = inl;
         if ($urandom_range(0, 1) == 1) begin
            write_reg(CSR_INL_ENABLE, enable_word);
            write_reg(CSR_BACKGROUND, bg);
         end else begin
            write_reg(CSR_BACKGROUND, bg);
            write_reg(CSR_INL_ENABLE, enable_word);
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Mid-phase, ask the response side for a long hold-off while requests keep coming
            if (n == ITEMS_PER_PHASE / 2 && (phase == 2 || phase == 5))
               hold_asks++;
            send_random_item();
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
